/* rtl/core/tsr_pkg.sv */
package tsr_pkg;

  // fixed field widths of the transfer payloads
  localparam int unsigned PortW   = 2;
  localparam int unsigned PosFldW = 11;
  localparam int unsigned DurW    = 16;

  // shared divider widths
  localparam int unsigned DivW    = DurW;
  localparam int unsigned DvsW    = DurW + 1;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // request kinds
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [PortW-1:0]   servo_port;
    logic [PosFldW-1:0] target_position;
    logic [DurW-1:0]    duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [PortW-1:0]   out_port;
    logic [PosFldW-1:0] out_position;
    logic               last;
  } out_item_t;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/tsr_div.sv */
module tsr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsr_pkg::div_req_t  req_i,
  output tsr_pkg::div_rsp_t  rsp_o
);

  logic                         run_q, run_d;
  logic [tsr_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [tsr_pkg::DivW-1:0]     rem_q, rem_d;
  logic [tsr_pkg::DivW-1:0]     quo_q, quo_d;
  logic [tsr_pkg::DvsW-1:0]     dvs_q, dvs_d;
  logic [tsr_pkg::DvsW-1:0]     trial;
  logic [tsr_pkg::DvsW-1:0]     diff;
  logic                         fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[tsr_pkg::DivW-1]};
  assign diff  = trial - dvs_q;
  assign fits  = (trial >= dvs_q);

  // sequencing of the quotient bits
  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = tsr_pkg::DivCntW'(tsr_pkg::DivW);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (run_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - tsr_pkg::DivCntW'(1);
      rem_d = fits ? diff[tsr_pkg::DivW-1:0] : trial[tsr_pkg::DivW-1:0];
      quo_d = {quo_q[tsr_pkg::DivW-2:0], fits};
    end else if (run_q) begin
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = run_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/core/timed_servo_ramp_unit.sv */
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+----------------------------
// in       | to unit   | in_valid_i / in_ready_o   | in_data_i  (move or ms tick)
// out      | from unit | out_valid_o / out_ready_i | out_data_o (port, pos, last)
//
// a tick or a command that gives no position leaves the unit idle; one that
// gives a position waits in the emit state for the output register to free up.
// a move with a nonzero duration runs three divisions in turn on the single
// 16-bit restoring divider (step size, step count, step period), then stages
// its first position, with any wait for the output register.
// reset sets every port to mid-scale and leaves the unit idle with no move.
// in_ready_o is low while a command is worked on or a result waits to be
// staged; a held output register does not block the next input transfer.
module timed_servo_ramp_unit #(
  parameter int unsigned SERVO_PORTS   = 4,
  parameter int unsigned POSITION_BITS = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsr_pkg::out_item_t out_data_o
);

  localparam int unsigned PosW = POSITION_BITS;
  localparam int unsigned IdxW = (SERVO_PORTS > 1) ? $clog2(SERVO_PORTS) : 1;
  localparam logic [PosW-1:0] PosReset = {1'b1, {(PosW-1){1'b0}}};

  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StDivStep   = 3'd1;
  localparam logic [2:0] StDivCount  = 3'd2;
  localparam logic [2:0] StDivPeriod = 3'd3;
  localparam logic [2:0] StEmit      = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [PosW-1:0]            pos_tab_q [SERVO_PORTS];
  logic                       busy_q, busy_d;
  logic                       out_valid_q, out_valid_d;
  tsr_pkg::out_item_t         out_data_q, out_data_d;
  tsr_pkg::out_item_t         pend_q, pend_d;
  logic [tsr_pkg::PortW-1:0]  act_port_q, act_port_d;
  logic [PosW-1:0]            goal_q, goal_d;
  logic                       up_q, up_d;
  logic [PosW-1:0]            step_q, step_d;
  logic [tsr_pkg::DurW-1:0]   period_q, period_d;
  logic [PosW-1:0]            total_q, total_d;
  logic [PosW-1:0]            index_q, index_d;
  logic [tsr_pkg::DurW-1:0]   tick_q, tick_d;
  logic [PosW-1:0]            run_pos_q, run_pos_d;
  logic [PosW-1:0]            dist_q, dist_d;
  logic [tsr_pkg::DurW-1:0]   dur_q, dur_d;

  logic                       accept;
  logic                       port_ok;
  logic [IdxW-1:0]            cmd_idx;
  logic [PosW-1:0]            cur;
  logic [PosW-1:0]            target;
  logic                       up_cmd;
  logic [PosW-1:0]            dist_cmd;
  logic [tsr_pkg::DurW-1:0]   tick_inc;
  logic [PosW-1:0]            step_pos;
  logic [PosW-1:0]            step_nxt;
  logic                       wr_en;
  logic [IdxW-1:0]            wr_idx;
  logic [PosW-1:0]            wr_pos;
  tsr_pkg::div_req_t          div_req;
  tsr_pkg::div_rsp_t          div_rsp;

  tsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // command decode and distance
  assign port_ok  = (32'(in_data_i.servo_port) < SERVO_PORTS);
  assign cmd_idx  = IdxW'(in_data_i.servo_port);
  assign cur      = pos_tab_q[cmd_idx];
  assign target   = PosW'(in_data_i.target_position);
  assign up_cmd   = (target > cur);
  assign dist_cmd = up_cmd ? (target - cur) : (cur - target);

  // ramp stepping
  assign tick_inc = tick_q + tsr_pkg::DurW'(1);
  assign step_pos = up_q ? (run_pos_q + step_q) : (run_pos_q - step_q);
  assign step_nxt = PosW'(div_rsp.quotient) + PosW'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    pend_d      = pend_q;
    act_port_d  = act_port_q;
    goal_d      = goal_q;
    up_d        = up_q;
    step_d      = step_q;
    period_d    = period_q;
    total_d     = total_q;
    index_d     = index_q;
    tick_d      = tick_q;
    run_pos_d   = run_pos_q;
    dist_d      = dist_q;
    dur_d       = dur_q;
    wr_en       = 1'b0;
    wr_idx      = IdxW'(act_port_q);
    wr_pos      = step_pos;
    div_req     = '0;
    unique case (state_q)
      StIdle: begin
        if (accept && (in_data_i.req_type == tsr_pkg::REQ_TICK)) begin
          if (busy_q) begin
            if (tick_inc < period_q) begin
              tick_d = tick_inc;
            end else begin
              tick_d  = '0;
              wr_en   = 1'b1;
              state_d = StEmit;
              pend_d.out_port = act_port_q;
              if (index_q < total_q) begin
                index_d             = index_q + PosW'(1);
                run_pos_d           = step_pos;
                wr_pos              = step_pos;
                pend_d.out_position = tsr_pkg::PosFldW'(step_pos);
                pend_d.last         = 1'b0;
              end else begin
                busy_d              = 1'b0;
                wr_pos              = goal_q;
                pend_d.out_position = tsr_pkg::PosFldW'(goal_q);
                pend_d.last         = 1'b1;
              end
            end
          end
        end else if (accept && !busy_q && port_ok && (cur != target)) begin
          if (in_data_i.duration_ms == '0) begin
            // zero duration: jump straight to the target
            wr_en               = 1'b1;
            wr_idx              = cmd_idx;
            wr_pos              = target;
            pend_d.out_port     = in_data_i.servo_port;
            pend_d.out_position = tsr_pkg::PosFldW'(target);
            pend_d.last         = 1'b1;
            state_d             = StEmit;
          end else begin
            act_port_d       = in_data_i.servo_port;
            goal_d           = target;
            up_d             = up_cmd;
            run_pos_d        = cur;
            dist_d           = dist_cmd;
            dur_d            = in_data_i.duration_ms;
            // step size = dist / (dur + 1) + 1
            div_req.start    = 1'b1;
            div_req.dividend = tsr_pkg::DivW'(dist_cmd);
            div_req.divisor  = tsr_pkg::DvsW'(in_data_i.duration_ms) + tsr_pkg::DvsW'(1);
            state_d          = StDivStep;
          end
        end
      end
      StDivStep: begin
        if (div_rsp.done) begin
          step_d           = step_nxt;
          div_req.start    = 1'b1;
          div_req.dividend = tsr_pkg::DivW'(dist_q);
          div_req.divisor  = tsr_pkg::DvsW'(step_nxt);
          state_d          = StDivCount;
        end
      end
      StDivCount: begin
        if (div_rsp.done) begin
          total_d          = PosW'(div_rsp.quotient);
          div_req.start    = 1'b1;
          div_req.dividend = dur_q;
          div_req.divisor  = tsr_pkg::DvsW'(div_rsp.quotient);
          state_d          = StDivPeriod;
        end
      end
      StDivPeriod: begin
        if (div_rsp.done) begin
          period_d            = div_rsp.quotient;
          index_d             = '0;
          tick_d              = '0;
          busy_d              = 1'b1;
          pend_d.out_port     = act_port_q;
          pend_d.out_position = tsr_pkg::PosFldW'(run_pos_q);
          pend_d.last         = 1'b0;
          state_d             = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = pend_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state and per-port positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SERVO_PORTS; i++) begin
        pos_tab_q[i] <= PosReset;
      end
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        pos_tab_q[wr_idx] <= wr_pos;
      end
    end
  end

  // move datapath
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    pend_q     <= pend_d;
    act_port_q <= act_port_d;
    goal_q     <= goal_d;
    up_q       <= up_d;
    step_q     <= step_d;
    period_q   <= period_d;
    total_q    <= total_d;
    index_q    <= index_d;
    tick_q     <= tick_d;
    run_pos_q  <= run_pos_d;
    dist_q     <= dist_d;
    dur_q      <= dur_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/tsr_chk.sv */
module tsr_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  tsr_pkg::in_item_t  in_data_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  tsr_pkg::out_item_t out_data_o
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // a fresh result is only staged while the input side is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result staged while input side was open");

  // reset leaves no result pending
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result pending after reset");

  // an input transfer that finds the unit idle and no result pending
  // cannot make a result appear in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after input transfer");

endmodule

bind timed_servo_ramp_unit tsr_chk u_tsr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/servo_write_checker.sv */
module servo_write_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  tsr_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  tsr_pkg::out_item_t out_data_i,
  output int                 errors_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPorts = 4;
  localparam int unsigned MidScale = 1 << (tsr_pkg::PosFldW - 1);

  // servo positions still to be written, oldest first
  tsr_pkg::out_item_t expected_writes[$];
  int                 mismatches = 0;

  // own copy of the ramp state
  logic [tsr_pkg::PosFldW-1:0] port_pos [NumPorts];
  bit                          ramp_busy;
  logic [tsr_pkg::PortW-1:0]   ramp_port;
  logic [tsr_pkg::PosFldW-1:0] ramp_from;
  logic [tsr_pkg::PosFldW-1:0] ramp_to;
  bit                          ramp_up;
  int unsigned                 ramp_step;
  int unsigned                 ramp_period;
  int unsigned                 ramp_steps;
  int unsigned                 ramp_index;
  int unsigned                 ms_count;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] servo write mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic record_write(input logic [tsr_pkg::PortW-1:0] port,
                              input logic [tsr_pkg::PosFldW-1:0] pos,
                              input logic fin);
    tsr_pkg::out_item_t w;
    port_pos[port] = pos;
    w.out_port     = port;
    w.out_position = pos;
    w.last         = fin;
    expected_writes.push_back(w);
  endtask

  // advance the ramp by one accepted request
  task automatic step_ramp(input tsr_pkg::in_item_t item);
    int unsigned cur;
    int unsigned span;
    int unsigned s;
    int unsigned off;
    if (item.req_type == tsr_pkg::REQ_TICK) begin
      if (ramp_busy) begin
        ms_count++;
        if (ms_count >= ramp_period) begin
          ms_count = 0;
          if (ramp_index < ramp_steps) begin
            ramp_index++;
            off = ramp_step * ramp_index;
            record_write(ramp_port,
                         tsr_pkg::PosFldW'(ramp_up ? ramp_from + off : ramp_from - off),
                         1'b0);
          end else begin
            ramp_busy = 1'b0;
            record_write(ramp_port, ramp_to, 1'b1);
          end
        end
      end
    end else if (!ramp_busy) begin
      cur = port_pos[item.servo_port];
      if (cur != item.target_position) begin
        if (item.duration_ms == '0) begin
          record_write(item.servo_port, item.target_position, 1'b1);
        end else begin
          ramp_up = item.target_position > cur;
          span = ramp_up ? item.target_position - cur : cur - item.target_position;
          // smallest step whose count fits in the duration
          s = 1;
          while (s < span && span / s > item.duration_ms) s++;
          ramp_port   = item.servo_port;
          ramp_from   = tsr_pkg::PosFldW'(cur);
          ramp_to     = item.target_position;
          ramp_step   = s;
          ramp_steps  = span / s;
          ramp_period = item.duration_ms / ramp_steps;
          ramp_index  = 0;
          ms_count    = 0;
          ramp_busy   = 1'b1;
          record_write(item.servo_port, tsr_pkg::PosFldW'(cur), 1'b0);
        end
      end
    end
  endtask

  task automatic check_write(input tsr_pkg::out_item_t got);
    tsr_pkg::out_item_t want;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write port %0d pos %0d last %0b",
                                got.out_port, got.out_position, got.last));
      return;
    end
    want = expected_writes.pop_front();
    if (got.out_port != want.out_port)
      report_mismatch($sformatf("port %0d, wanted %0d", got.out_port, want.out_port));
    if (got.out_position != want.out_position)
      report_mismatch($sformatf("position %0d, wanted %0d on port %0d",
                                got.out_position, want.out_position, want.out_port));
    if (got.last != want.last)
      report_mismatch($sformatf("last %0b, wanted %0b on port %0d pos %0d",
                                got.last, want.last, want.out_port, want.out_position));
  endtask

  // outputs cannot stem from the input of the same edge, so check them first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPorts; p++) port_pos[p] = tsr_pkg::PosFldW'(MidScale);
      ramp_busy   = 1'b0;
      ramp_port   = '0;
      ramp_from   = '0;
      ramp_to     = '0;
      ramp_up     = 1'b0;
      ramp_step   = 0;
      ramp_period = 0;
      ramp_steps  = 0;
      ramp_index  = 0;
      ms_count    = 0;
      expected_writes.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_write(out_data_i);
      if (in_valid_i && in_ready_i) step_ramp(in_data_i);
      outstanding_o <= expected_writes.size();
    end
  end

endmodule

/* tb/sv/timed_servo_ramp_unit_test.sv */
module timed_servo_ramp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit       = 5000;
  localparam int DrainCycles     = 100;
  localparam int RandomItems     = 1650;
  localparam int HoldCycles      = 400;
  localparam int HoldAfterWrites = 300;

  typedef enum {SINK_ALWAYS, SINK_COIN, SINK_BURSTY} sink_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  tsr_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tsr_pkg::out_item_t out_data_o;

  int errors;
  int outstanding;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  timed_servo_ramp_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  servo_write_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  // offer one request, in bursts with random gaps, and wait for its transfer
  task automatic push_item(input tsr_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_move(input int port, input int target, input int dur);
    tsr_pkg::in_item_t item;
    item.req_type        = tsr_pkg::REQ_MOVE;
    item.servo_port      = tsr_pkg::PortW'(port);
    item.target_position = tsr_pkg::PosFldW'(target);
    item.duration_ms     = tsr_pkg::DurW'(dur);
    push_item(item);
  endtask

  // millisecond ticks; the unused fields carry noise
  task automatic send_ticks(input int n);
    tsr_pkg::in_item_t item;
    for (int k = 0; k < n; k++) begin
      item.req_type        = tsr_pkg::REQ_TICK;
      item.servo_port      = tsr_pkg::PortW'($urandom);
      item.target_position = tsr_pkg::PosFldW'($urandom);
      item.duration_ms     = tsr_pkg::DurW'($urandom);
      push_item(item);
    end
  endtask

  function automatic int pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return (1 << tsr_pkg::PosFldW) - 1;
    return $urandom_range(0, (1 << tsr_pkg::PosFldW) - 1);
  endfunction

  // mostly short moves so that many of them fit in the run
  function automatic int pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 60);
    return $urandom_range(61, 300);
  endfunction

  // request stimulus and verdict
  initial begin : stimulus
    int random_start;
    int pick;
    int port;
    int target;
    int dur;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases
    send_ticks(1);                          // tick with no move running
    send_move(0, 1024, 5);                  // already at the target
    send_move(0, 0, 0);                     // zero duration jump to the bottom
    send_move(1, 2047, 0);                  // zero duration jump to the top
    send_move(2, 1030, 3);                  // step of two, one tick apart
    send_ticks(2);
    send_move(3, 100, 1);                   // dropped while a move runs
    send_ticks(5);
    send_move(0, 2047, 1);                  // full span, one step of 1024 then the goal
    send_ticks(3);
    send_move(1, 0, 7);                     // downward, goal off the step grid
    send_ticks(15);
    send_move(2, 1031, 4);                  // one unit with a long step time
    send_ticks(9);
    send_move(3, 0, 0);
    send_move(3, 2047, 300);                // widest move over a long duration
    send_ticks(301);

    // random moves, mostly run to completion
    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      pick   = $urandom_range(0, 99);
      port   = $urandom_range(0, 3);
      target = pick_target();
      dur    = pick_duration();
      if (pick < 75) begin
        send_move(port, target, dur);
        if ($urandom_range(0, 4) == 0) begin
          send_ticks($urandom_range(0, dur));
          send_move($urandom_range(0, 3), pick_target(), pick_duration());
        end
        // a move never needs more than twice its duration in ticks
        send_ticks(2 * dur + 1);
        if ($urandom_range(0, 9) == 0) send_move(port, target, dur);
      end else if (pick < 90) begin
        send_move(port, target, dur);
        send_ticks($urandom_range(0, dur));
      end else if ($urandom_range(0, 1) == 0) begin
        send_ticks($urandom_range(1, 5));
      end else begin
        send_move(port, target, dur);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: changing stall patterns plus one long hold-off
  initial begin : receiver
    sink_mode_e mode       = SINK_ALWAYS;
    int         mode_left  = 0;
    int         stall_left = 0;
    int         hold_left  = 0;
    int         writes     = 0;
    bit         held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) writes++;
      if (!held && writes >= HoldAfterWrites) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          SINK_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          SINK_COIN: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 30);
            end
          end
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
